// ===== design/qoi_chunk_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// qoi_chunk_decoder_assert.svh
// Assertion macros for the QOI chunk decoder checker.
// ----------------------------------------------------------------------------
`ifndef QOI_CHUNK_DECODER_ASSERT_SVH
`define QOI_CHUNK_DECODER_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define QOICD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qoicd assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define QOICD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qoicd assertion failed");

`endif

// ===== design/qoicd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoicd_pkg
// Types, chunk codes and the colour table hash for the QOI chunk decoder.
// ----------------------------------------------------------------------------
package qoicd_pkg;

    localparam int TABLE_BITS = 6;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int COUNT_BITS = 6;

    localparam logic [7:0] TAG_MASK  = 8'hC0;
    localparam logic [7:0] TAG_INDEX = 8'h00;
    localparam logic [7:0] TAG_DIFF  = 8'h40;
    localparam logic [7:0] TAG_LUMA  = 8'h80;
    localparam logic [7:0] TAG_RUN   = 8'hC0;
    localparam logic [7:0] TAG_RGB   = 8'hFE;
    localparam logic [7:0] TAG_RGBA  = 8'hFF;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RGB  = 2'd1;
    localparam logic [1:0] KIND_RGBA = 2'd2;
    localparam logic [1:0] KIND_LUMA = 2'd3;

    localparam logic [2:0] LEFT_RGB  = 3'd3;
    localparam logic [2:0] LEFT_RGBA = 3'd4;
    localparam logic [2:0] LEFT_LUMA = 3'd1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    localparam pixel_t PIXEL_START = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    typedef struct packed {
        logic take_byte;
        logic load_index;
        logic write_pixel;
        logic out_beat;
    } cmd_t;

    typedef struct packed {
        logic pixel_now;
        logic index_now;
        logic count_zero;
    } status_t;

    function automatic logic [TABLE_BITS-1:0] slot_of(input pixel_t px);
        logic [7:0] sum;
        sum = px.r * 8'd3 + px.g * 8'd5 + px.b * 8'd7 + px.a * 8'd11;
        return sum[TABLE_BITS-1:0];
    endfunction

endpackage

// ===== design/qoicd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoicd_datapath
// Chunk gathering, pixel arithmetic, previous pixel and colour table.
// ----------------------------------------------------------------------------
module qoicd_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         data_byte,
    input  logic               image_start,
    input  qoicd_pkg::cmd_t    cmd,
    output qoicd_pkg::status_t status,
    output qoicd_pkg::pixel_t  pixel,
    output logic               last_pixel
);

    logic [1:0]                          kind_reg, kind_next;
    logic [2:0]                          left_reg, left_next;
    logic [23:0]                         gath_reg, gath_next;
    qoicd_pkg::pixel_t                   prev_reg, prev_next;
    qoicd_pkg::pixel_t                   pix_reg, pix_next;
    logic [qoicd_pkg::COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [qoicd_pkg::TABLE_SIZE-1:0]    valid_reg, valid_next;
    logic [qoicd_pkg::TABLE_BITS-1:0]    idx_reg;
    qoicd_pkg::pixel_t                   rd_q;
    qoicd_pkg::pixel_t                   mem [qoicd_pkg::TABLE_SIZE];

    logic [1:0]                          eff_kind, d_kind;
    logic [2:0]                          eff_left, d_left;
    logic [23:0]                         d_gath;
    logic [31:0]                         cat;
    qoicd_pkg::pixel_t                   eff_prev, d_pixel;
    logic [qoicd_pkg::COUNT_BITS-1:0]    d_count;
    logic                                gathering, d_pixel_now, d_index_now;
    logic [7:0]                          vg, dr, db;
    logic [qoicd_pkg::TABLE_BITS-1:0]    wr_slot;

    assign eff_kind  = image_start ? qoicd_pkg::KIND_NONE : kind_reg;
    assign eff_left  = image_start ? 3'd0 : left_reg;
    assign eff_prev  = image_start ? qoicd_pkg::PIXEL_START : prev_reg;
    assign gathering = (eff_kind != qoicd_pkg::KIND_NONE) && (eff_left != 3'd0);
    assign cat       = {gath_reg, data_byte};
    assign wr_slot   = qoicd_pkg::slot_of(pix_reg);

    // LUMA: first byte in cat[15:8], second in cat[7:0]
    assign vg = {2'b00, cat[13:8]} - 8'd32;
    assign dr = vg + {4'b0000, cat[7:4]} - 8'd8;
    assign db = vg + {4'b0000, cat[3:0]} - 8'd8;

    always_comb begin
        d_kind      = qoicd_pkg::KIND_NONE;
        d_left      = 3'd0;
        d_gath      = 24'd0;
        d_pixel     = eff_prev;
        d_count     = '0;
        d_pixel_now = 1'b0;
        d_index_now = 1'b0;
        if (gathering) begin
            d_kind = eff_kind;
            d_left = eff_left - 3'd1;
            d_gath = cat[23:0];
            if (eff_left == 3'd1) begin
                d_kind      = qoicd_pkg::KIND_NONE;
                d_gath      = 24'd0;
                d_pixel_now = 1'b1;
                case (eff_kind)
                    qoicd_pkg::KIND_RGB: begin
                        d_pixel = '{r: cat[23:16], g: cat[15:8], b: cat[7:0], a: eff_prev.a};
                    end
                    qoicd_pkg::KIND_RGBA: begin
                        d_pixel = '{r: cat[31:24], g: cat[23:16], b: cat[15:8], a: cat[7:0]};
                    end
                    qoicd_pkg::KIND_LUMA: begin
                        d_pixel = '{r: eff_prev.r + dr, g: eff_prev.g + vg,
                                    b: eff_prev.b + db, a: eff_prev.a};
                    end
                    default: begin
                        d_pixel = eff_prev;
                    end
                endcase
            end
        end else if (data_byte == qoicd_pkg::TAG_RGB) begin
            d_kind = qoicd_pkg::KIND_RGB;
            d_left = qoicd_pkg::LEFT_RGB;
        end else if (data_byte == qoicd_pkg::TAG_RGBA) begin
            d_kind = qoicd_pkg::KIND_RGBA;
            d_left = qoicd_pkg::LEFT_RGBA;
        end else begin
            case (data_byte & qoicd_pkg::TAG_MASK)
                qoicd_pkg::TAG_INDEX: begin
                    d_index_now = 1'b1;
                end
                qoicd_pkg::TAG_DIFF: begin
                    d_pixel_now = 1'b1;
                    d_pixel = '{r: eff_prev.r + {6'd0, data_byte[5:4]} - 8'd2,
                                g: eff_prev.g + {6'd0, data_byte[3:2]} - 8'd2,
                                b: eff_prev.b + {6'd0, data_byte[1:0]} - 8'd2,
                                a: eff_prev.a};
                end
                qoicd_pkg::TAG_LUMA: begin
                    d_kind = qoicd_pkg::KIND_LUMA;
                    d_left = qoicd_pkg::LEFT_LUMA;
                    d_gath = {16'd0, data_byte};
                end
                default: begin
                    d_pixel_now = 1'b1;
                    d_count     = data_byte[qoicd_pkg::COUNT_BITS-1:0];
                end
            endcase
        end
    end

    always_comb begin
        kind_next  = kind_reg;
        left_next  = left_reg;
        gath_next  = gath_reg;
        prev_next  = prev_reg;
        pix_next   = pix_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (cmd.take_byte) begin
            kind_next = d_kind;
            left_next = d_left;
            gath_next = d_gath;
            if (image_start) begin
                valid_next = '0;
                prev_next  = qoicd_pkg::PIXEL_START;
            end
            if (d_pixel_now) begin
                pix_next = d_pixel;
                cnt_next = d_count;
            end
        end
        if (cmd.load_index) begin
            pix_next = valid_reg[idx_reg] ? rd_q : '0;
            cnt_next = '0;
        end
        if (cmd.write_pixel) begin
            prev_next           = pix_reg;
            valid_next[wr_slot] = 1'b1;
        end
        if (cmd.out_beat && (cnt_reg != '0)) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= qoicd_pkg::KIND_NONE;
            left_reg  <= 3'd0;
            gath_reg  <= 24'd0;
            prev_reg  <= qoicd_pkg::PIXEL_START;
            cnt_reg   <= '0;
            valid_reg <= '0;
        end else begin
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            gath_reg  <= gath_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        if (cmd.take_byte) begin
            idx_reg <= data_byte[qoicd_pkg::TABLE_BITS-1:0];
        end
    end

    // colour table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.write_pixel) begin
            mem[wr_slot] <= pix_reg;
        end
        if (cmd.take_byte) begin
            rd_q <= mem[data_byte[qoicd_pkg::TABLE_BITS-1:0]];
        end
    end

    assign status.pixel_now  = d_pixel_now;
    assign status.index_now  = d_index_now;
    assign status.count_zero = (cnt_reg == '0);
    assign pixel             = pix_reg;
    assign last_pixel        = (cnt_reg == '0);

endmodule

// ===== design/qoicd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoicd_ctrl
// Sequencer: byte intake, table read, pixel output beats.
// ----------------------------------------------------------------------------
module qoicd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  qoicd_pkg::status_t status,
    output qoicd_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       take, beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign take     = s_tvalid && s_tready;
    assign beat     = m_tvalid && m_tready;

    assign cmd.take_byte   = take;
    assign cmd.load_index  = (state_reg == ST_READ);
    assign cmd.write_pixel = (state_reg == ST_EMIT);
    assign cmd.out_beat    = beat;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && status.index_now) begin
                    state_next = ST_READ;
                end else if (take && status.pixel_now) begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (beat && status.count_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/qoi_chunk_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_chunk_decoder
// QOI chunk stream to pixels, one byte in per beat.
// ----------------------------------------------------------------------------
// channel   dir  tdata                          tuser          tlast
// s_        in   data_byte[7:0]                 image_start    -
// m_        out  red, green, blue, alpha (8b)   -              last_pixel
//
// Tag bytes of RGB/RGBA/LUMA and all but the final data byte of a chunk: taken, no output.
// Byte finishing DIFF/RGB/RGBA/LUMA: intake, then its pixel beat.
// INDEX: intake, then the colour table read (registered), then its beat; RUN: intake, then a beat per run pixel.
// Input is held off while pixels are being output; m_ stalls hold the beat.
// Reset: no clearing pass; table entries carry valid bits cleared at once.
// ----------------------------------------------------------------------------
module qoi_chunk_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] image_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic        m_tlast    // last_pixel
);

    qoicd_pkg::cmd_t    cmd;
    qoicd_pkg::status_t status;
    qoicd_pkg::pixel_t  pixel;

    qoicd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qoicd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_tdata),
        .image_start (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .pixel       (pixel),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {pixel.a, pixel.b, pixel.g, pixel.r};

endmodule

// ===== design/qoicd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoicd_checker
// Port-level checks on beat ordering of the QOI chunk decoder.
// ----------------------------------------------------------------------------
`include "qoi_chunk_decoder_assert.svh"

module qoicd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    `QOICD_ASSERT_NOW(a_no_intake_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `QOICD_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)
    `QOICD_ASSERT_NEXT(a_last_ends_output, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `QOICD_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

endmodule

bind qoi_chunk_decoder qoicd_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for qoi_chunk_decoder. A short table of hand-picked
// chunk bytes is walked first, then random, mostly well-formed chunk
// sequences under varying idle and stall patterns. An in-bench decoder
// model predicts every pixel beat; beats are checked in order as they
// leave the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [7:0]        code;
        logic              st;
        logic              typed;
        qoicd_pkg::pixel_t px;
    } row_t;

    typedef struct packed {
        qoicd_pkg::pixel_t px;
        logic              last;
    } beat_t;

    // typed rows carry the pixel expected on that byte
    localparam row_t PLAN [24] = '{
        '{qoicd_pkg::TAG_RUN,              1'b1, 1'b1, 32'h000000FF},
        '{qoicd_pkg::TAG_INDEX | 8'd53,    1'b0, 1'b1, 32'h000000FF},
        '{qoicd_pkg::TAG_DIFF,             1'b0, 1'b1, 32'hFEFEFEFF},
        '{qoicd_pkg::TAG_DIFF | 8'h3F,     1'b0, 1'b1, 32'hFFFFFFFF},
        '{qoicd_pkg::TAG_RGB,              1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_RGB,              1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_RGBA,             1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_RUN,              1'b0, 1'b1, 32'hFEFFC0FF},
        '{qoicd_pkg::TAG_RGBA,             1'b0, 1'b0, 32'h0},
        '{8'h00,                           1'b0, 1'b0, 32'h0},
        '{8'hFF,                           1'b0, 1'b0, 32'h0},
        '{8'h80,                           1'b0, 1'b0, 32'h0},
        '{8'h01,                           1'b0, 1'b1, 32'h00FF8001},
        '{qoicd_pkg::TAG_LUMA,             1'b0, 1'b0, 32'h0},
        '{8'h00,                           1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_LUMA | 8'h3F,     1'b0, 1'b0, 32'h0},
        '{8'hFF,                           1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_RUN | 8'd61,      1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_INDEX | 8'd63,    1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_RGB,              1'b0, 1'b0, 32'h0},
        '{8'hAA,                           1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_INDEX,            1'b1, 1'b1, 32'h00000000},
        '{qoicd_pkg::TAG_LUMA,             1'b0, 1'b0, 32'h0},
        '{qoicd_pkg::TAG_DIFF | 8'h3F,     1'b1, 1'b1, 32'h010101FF}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    qoicd_pkg::pixel_t last_px;
    qoicd_pkg::pixel_t colour_table [qoicd_pkg::TABLE_SIZE];
    logic [1:0]        pend_kind;
    logic [2:0]        pend_left;
    logic [31:0]       pend_bytes;
    beat_t             pixels_due [$];

    int mismatches = 0;
    int sent_bytes = 0;
    int cycles     = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    bit force_start = 1'b0;

    always #5 aclk = ~aclk;

    qoi_chunk_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic logic [5:0] colour_slot(input qoicd_pkg::pixel_t px);
        int sum;
        sum = px.r * 3 + px.g * 5 + px.b * 7 + px.a * 11;
        return sum[5:0];
    endfunction

    function automatic void restart_image();
        last_px = qoicd_pkg::PIXEL_START;
        foreach (colour_table[i]) colour_table[i] = '0;
        pend_kind  = qoicd_pkg::KIND_NONE;
        pend_left  = '0;
        pend_bytes = '0;
    endfunction

    // n pixels of value px result from this byte
    function automatic void decode_byte(input logic [7:0] code, input logic st,
                                        output int n, output qoicd_pkg::pixel_t px);
        qoicd_pkg::pixel_t base;
        logic [7:0]        vg;
        n  = 0;
        px = '0;
        if (st) restart_image();
        base = last_px;
        if (pend_kind != qoicd_pkg::KIND_NONE && pend_left != 0) begin
            pend_bytes = {pend_bytes[23:0], code};
            pend_left  = pend_left - 3'd1;
            if (pend_left != 0) return;
            case (pend_kind)
                qoicd_pkg::KIND_RGB: begin
                    px = {pend_bytes[23:0], base.a};
                end
                qoicd_pkg::KIND_RGBA: begin
                    px = pend_bytes;
                end
                default: begin
                    vg   = {2'b00, pend_bytes[13:8]} - 8'd32;
                    px.r = base.r + vg + pend_bytes[7:4] - 8'd8;
                    px.g = base.g + vg;
                    px.b = base.b + vg + pend_bytes[3:0] - 8'd8;
                    px.a = base.a;
                end
            endcase
            pend_kind  = qoicd_pkg::KIND_NONE;
            pend_bytes = '0;
            n = 1;
        end else begin
            pend_kind  = qoicd_pkg::KIND_NONE;
            pend_left  = '0;
            pend_bytes = '0;
            if (code == qoicd_pkg::TAG_RGB) begin
                pend_kind = qoicd_pkg::KIND_RGB;
                pend_left = qoicd_pkg::LEFT_RGB;
                return;
            end
            if (code == qoicd_pkg::TAG_RGBA) begin
                pend_kind = qoicd_pkg::KIND_RGBA;
                pend_left = qoicd_pkg::LEFT_RGBA;
                return;
            end
            case (code & qoicd_pkg::TAG_MASK)
                qoicd_pkg::TAG_INDEX: begin
                    px = colour_table[code[5:0]];
                    n  = 1;
                end
                qoicd_pkg::TAG_DIFF: begin
                    px.r = base.r + code[5:4] - 8'd2;
                    px.g = base.g + code[3:2] - 8'd2;
                    px.b = base.b + code[1:0] - 8'd2;
                    px.a = base.a;
                    n    = 1;
                end
                qoicd_pkg::TAG_LUMA: begin
                    pend_kind  = qoicd_pkg::KIND_LUMA;
                    pend_left  = qoicd_pkg::LEFT_LUMA;
                    pend_bytes = {24'd0, code};
                    return;
                end
                default: begin
                    px = base;
                    n  = code[5:0] + 1;
                end
            endcase
        end
        last_px = px;
        colour_table[colour_slot(px)] = px;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic void report(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    task automatic send_byte(input logic [7:0] code, input logic st,
                             input logic typed, input qoicd_pkg::pixel_t typed_px);
        int                n;
        qoicd_pkg::pixel_t px;
        beat_t             due;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
        decode_byte(code, st, n, px);
        if (typed) px = typed_px;
        for (int k = 1; k <= n; k++) begin
            due.px   = px;
            due.last = (k == n);
            pixels_due.insert(pixels_due.size(), due);
        end
    endtask

    task automatic one_chunk();
        logic [7:0] r8;
        logic [5:0] len;
        logic       st;
        r8 = rand_byte();
        st = force_start || ($urandom_range(24) == 0);
        force_start = 1'b0;
        case ($urandom_range(19))
            0, 1, 2, 3: begin
                send_byte(qoicd_pkg::TAG_INDEX | {2'b00, r8[5:0]}, st, 1'b0, '0);
            end
            4, 5, 6: begin
                send_byte(qoicd_pkg::TAG_DIFF | {2'b00, r8[5:0]}, st, 1'b0, '0);
            end
            7, 8, 9: begin
                send_byte(qoicd_pkg::TAG_LUMA | {2'b00, r8[5:0]}, st, 1'b0, '0);
                send_byte(rand_byte(), 1'b0, 1'b0, '0);
            end
            10, 11, 12: begin
                len = ($urandom_range(7) == 0) ? 6'($urandom_range(61))
                                               : 6'($urandom_range(7));
                send_byte(qoicd_pkg::TAG_RUN | {2'b00, len}, st, 1'b0, '0);
            end
            13, 14: begin
                send_byte(qoicd_pkg::TAG_RGB, st, 1'b0, '0);
                repeat (3) send_byte(rand_byte(), 1'b0, 1'b0, '0);
            end
            15, 16: begin
                send_byte(qoicd_pkg::TAG_RGBA, st, 1'b0, '0);
                repeat (4) send_byte(rand_byte(), 1'b0, 1'b0, '0);
            end
            17: begin
                // cut short by an image start on the next chunk
                send_byte(r8[0] ? qoicd_pkg::TAG_RGBA : qoicd_pkg::TAG_RGB, st, 1'b0, '0);
                repeat ($urandom_range(2)) send_byte(rand_byte(), 1'b0, 1'b0, '0);
                force_start = 1'b1;
            end
            default: begin
                send_byte(r8, st, 1'b0, '0);
            end
        endcase
    endtask

    task automatic send_chunks(input int count);
        int target;
        target = sent_bytes + count;
        while (sent_bytes < target) one_chunk();
    endtask

    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        beat_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixels_due.size() == 0) begin
                report($sformatf("unexpected pixel beat %h last %0b", m_tdata, m_tlast));
            end else begin
                due = pixels_due.pop_front();
                if (m_tdata[7:0] != due.px.r || m_tdata[15:8] != due.px.g ||
                    m_tdata[23:16] != due.px.b || m_tdata[31:24] != due.px.a ||
                    m_tlast != due.last) begin
                    report($sformatf(
                        "pixel rgba exp %h %h %h %h last %0b, got %h %h %h %h last %0b",
                        due.px.r, due.px.g, due.px.b, due.px.a, due.last,
                        m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                        m_tdata[31:24], m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        restart_image();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PLAN[i]) send_byte(PLAN[i].code, PLAN[i].st, PLAN[i].typed, PLAN[i].px);

        for (int p = 0; p < 4; p++) begin
            send_idle  = (p == 1) ? 78 : (p == 3) ? 16 : 0;
            recv_stall = (p == 2) ? 78 : (p == 3) ? 16 : 0;
            send_chunks(75);
            if (p == 0) begin
                // long output back-pressure while bytes keep coming
                hold_reqs++;
                send_chunks(40);
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pixels_due.size() != 0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixels_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/qoicd_pkg.sv
design/qoicd_datapath.sv
design/qoicd_ctrl.sv
design/qoi_chunk_decoder.sv
design/qoicd_checker.sv
tb/tb.sv
